/* rtl/md5sh_pkg.sv */
// Shared types, constants and round functions for the MD5 stream hasher.
`default_nettype none
package md5sh_pkg;

  localparam int BLOCK_BYTES = 64;
  localparam int RND_W       = 6;
  localparam int MIDX_W      = 4;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef logic [31:0]      word_t;
  typedef logic [3:0][31:0] chain_t;

  // index 0 is A
  localparam chain_t INIT_CHAIN = {32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301};

  localparam logic [31:0] ROUND_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef struct packed {
    logic             load;
    logic             prime;
    logic             step;
    logic             fin;
    logic             init;
    logic [RND_W-1:0] rnd;
  } rnd_ctl_t;

  function automatic logic [MIDX_W-1:0] msg_index(input logic [RND_W-1:0] i);
    logic [MIDX_W-1:0] j;
    logic [MIDX_W-1:0] g;
    j = i[MIDX_W-1:0];
    case (i[5:4])
      2'd0:    g = j;
      2'd1:    g = MIDX_W'(j * 4'd5 + 4'd1);
      2'd2:    g = MIDX_W'(j * 4'd3 + 4'd5);
      default: g = MIDX_W'(j * 4'd7);
    endcase
    return g;
  endfunction

  function automatic word_t round_f(input logic [1:0] ph, input word_t b, input word_t c,
                                    input word_t d);
    word_t f;
    case (ph)
      2'd0:    f = d ^ (b & (c ^ d));
      2'd1:    f = c ^ (d & (b ^ c));
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic word_t rotl(input word_t x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage
`default_nettype wire

/* rtl/md5sh_in_if.sv */
// Message item channel: valid/ready with data bytes, byte count and end mark.
`default_nettype none
interface md5sh_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  byte_count;
  logic        end_of_message;

  modport source(output valid, output data_word, output byte_count, output end_of_message,
                 input ready);
  modport sink(input valid, input data_word, input byte_count, input end_of_message,
               output ready);
endinterface
`default_nettype wire

/* rtl/md5sh_out_if.sv */
// Digest item channel: valid/ready with one digest word and its index.
`default_nettype none
interface md5sh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;

  modport source(output valid, output digest_word, output word_index, output last_word,
                 input ready);
  modport sink(input valid, input digest_word, input word_index, input last_word,
               output ready);
endinterface
`default_nettype wire

/* rtl/md5sh_block_ram.sv */
// Block buffer memory: byte-lane write port, registered read port.
`default_nettype none
module md5sh_block_ram #(
  parameter int WORDS = md5sh_pkg::BLOCK_BYTES / 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(WORDS)-1:0] waddr,
  input  wire logic [3:0]               wbe,
  input  wire logic [31:0]              wdata,
  input  wire logic [$clog2(WORDS)-1:0] raddr,
  output      logic [31:0]              rdata
);

  logic [3:0][7:0] mem [WORDS];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (we && wbe[k]) begin
        mem[waddr][k] <= wdata[8*k +: 8];
      end
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/md5sh_round_unit.sv */
// MD5 round datapath: working variables, pre-added operand and chaining value.
`default_nettype none
module md5sh_round_unit (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire md5sh_pkg::rnd_ctl_t ctl,
  input  wire md5sh_pkg::word_t    mword,
  output      md5sh_pkg::chain_t   chain
);

  md5sh_pkg::word_t a, b, c, d, pre;
  md5sh_pkg::word_t f, b_new;
  logic [4:0]       s;

  always_comb begin
    f     = md5sh_pkg::round_f(ctl.rnd[5:4], b, c, d);
    s     = md5sh_pkg::ROT_AMT[{ctl.rnd[5:4], ctl.rnd[1:0]}];
    b_new = b + md5sh_pkg::rotl(pre + f, s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain <= md5sh_pkg::INIT_CHAIN;
    end else if (ctl.init) begin
      chain <= md5sh_pkg::INIT_CHAIN;
    end else if (ctl.fin) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (ctl.prime) begin
      pre <= a + md5sh_pkg::ROUND_K[0] + mword;
    end else if (ctl.step) begin
      a   <= d;
      b   <= b_new;
      c   <= b;
      d   <= c;
      // d becomes next round's a
      pre <= d + md5sh_pkg::ROUND_K[md5sh_pkg::RND_W'(ctl.rnd + 1'b1)] + mword;
    end
  end

endmodule
`default_nettype wire

/* rtl/md5sh_out_queue.sv */
// Digest output register: holds the four words and sends them one per item.
`default_nettype none
module md5sh_out_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire md5sh_pkg::chain_t words,
  output      logic              busy,
  md5sh_out_if.source            dig
);

  md5sh_pkg::chain_t held;
  logic [1:0]        idx;

  assign dig.valid       = busy;
  assign dig.digest_word = held[idx];
  assign dig.word_index  = idx;
  assign dig.last_word   = (idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (load && !busy) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (busy && dig.ready) begin
      idx <= idx + 2'd1;
      if (idx == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !busy) begin
      held <= words;
    end
  end

  a_start_at_a: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> idx == 2'd0)
    else $error("digest burst does not start at word A");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    dig.valid && dig.ready && dig.last_word |=> !busy)
    else $error("queue still busy after last digest word");

endmodule
`default_nettype wire

/* rtl/md5_stream_hasher.sv */
// MD5 stream hasher top level: block sequencer, buffer memory, rounds, output.
//
// msg takes message items of zero to four bytes (byte_count above four counts
// as four), first byte in data_word[7:0]. dig gives four digest words, A to D,
// after each item with end_of_message set; last_word marks D.
// An item that stays inside one buffer word is written in one write,
// one that crosses a word boundary in two. Each full 64-byte block
// adds a compression: one round per cycle on the shared round unit,
// fed from the single read port of the block buffer. The end of a
// message adds the pad mark and pad words, one or two compressions
// and the digest hand-over; the first digest word is valid after that.
// msg.ready is low while an item is being worked on. A stalled
// receiver holds the digest words; the next message may
// stream in meanwhile, and its end waits until the held digest has gone out.
// Reset restores the initial chaining value and a zero length; the block
// buffer needs no clearing.
`default_nettype none
module md5_stream_hasher #(
  parameter int BLOCK_BYTES = md5sh_pkg::BLOCK_BYTES
) (
  input  wire logic   clk,
  input  wire logic   rst,
  md5sh_in_if.sink    msg,
  md5sh_out_if.source dig
);

  localparam int WORDS = BLOCK_BYTES / 4;
  localparam int AW    = $clog2(WORDS);
  localparam int OFS_W = $clog2(BLOCK_BYTES);

  typedef enum logic [3:0] {
    S_IDLE, S_HI, S_MARK, S_FILL, S_ADDR, S_PRIME, S_ROUND, S_FINAL, S_EMIT
  } state_t;

  state_t                      st;
  logic [63:0]                 len;
  logic [AW-1:0]               hi_addr;
  logic [31:0]                 hi_data;
  logic [3:0]                  hi_be;
  logic                        pend_hi, pend_end, pad_active, extra;
  logic [AW-1:0]               fill_ptr;
  logic [md5sh_pkg::RND_W-1:0] rnd;

  logic          accept;
  logic [2:0]    n;
  logic [1:0]    o;
  logic [AW-1:0] w;
  logic [63:0]   shifted;
  logic [3:0]    low_mask;
  logic [7:0]    mask8;
  logic          full, spill;
  logic [63:0]   bits;
  logic [31:0]   fill_word;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [3:0]    ram_wbe;
  logic [31:0]   ram_wdata, ram_rdata;

  md5sh_pkg::rnd_ctl_t ctl;
  md5sh_pkg::chain_t   chain;
  logic                q_load, q_busy;

  assign msg.ready = (st == S_IDLE);
  assign accept    = msg.valid && msg.ready;

  always_comb begin
    n        = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;
    o        = len[1:0];
    w        = len[OFS_W-1:2];
    shifted  = {32'b0, msg.data_word} << {o, 3'b000};
    low_mask = 4'b1111 >> (3'd4 - n);
    mask8    = {4'b0, low_mask} << o;
    full     = mask8[3] && (w == AW'(WORDS - 1));
    spill    = |mask8[7:4];
    bits     = {len[60:0], 3'b000};
    if (extra) begin
      fill_word = '0;
    end else if (fill_ptr == AW'(WORDS - 2)) begin
      fill_word = bits[31:0];
    end else if (fill_ptr == AW'(WORDS - 1)) begin
      fill_word = bits[63:32];
    end else begin
      fill_word = '0;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w;
    ram_wbe   = mask8[3:0];
    ram_wdata = shifted[31:0];
    ram_raddr = AW'(md5sh_pkg::msg_index('0));
    ctl       = '0;
    ctl.rnd   = rnd;
    q_load    = 1'b0;
    unique case (st)
      S_IDLE: begin
        ram_we = accept;
      end
      S_HI: begin
        ram_we    = 1'b1;
        ram_waddr = hi_addr;
        ram_wbe   = hi_be;
        ram_wdata = hi_data;
      end
      S_MARK: begin
        ram_we    = 1'b1;
        ram_wbe   = 4'b1111 << o;
        ram_wdata = 32'(md5sh_pkg::PAD_MARK) << {o, 3'b000};
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_ptr;
        ram_wbe   = 4'b1111;
        ram_wdata = fill_word;
      end
      S_ADDR: begin
        ctl.load = 1'b1;
      end
      S_PRIME: begin
        ctl.prime = 1'b1;
        ram_raddr = AW'(md5sh_pkg::msg_index(md5sh_pkg::RND_W'(1)));
      end
      S_ROUND: begin
        ctl.step  = 1'b1;
        ram_raddr = AW'(md5sh_pkg::msg_index(md5sh_pkg::RND_W'(rnd + 2'd2)));
      end
      S_FINAL: begin
        ctl.fin = 1'b1;
      end
      S_EMIT: begin
        q_load   = !q_busy;
        ctl.init = !q_busy;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      len        <= '0;
      pend_hi    <= 1'b0;
      pend_end   <= 1'b0;
      pad_active <= 1'b0;
      extra      <= 1'b0;
      fill_ptr   <= '0;
      rnd        <= '0;
    end else begin
      unique case (st)
        S_IDLE: begin
          if (accept) begin
            len      <= len + 64'(n);
            hi_addr  <= w + 1'b1;
            hi_data  <= shifted[63:32];
            hi_be    <= mask8[7:4];
            pend_hi  <= spill;
            pend_end <= msg.end_of_message;
            if (full) begin
              st <= S_ADDR;
            end else if (spill) begin
              st <= S_HI;
            end else if (msg.end_of_message) begin
              st <= S_MARK;
            end
          end
        end
        S_HI: begin
          pend_hi <= 1'b0;
          st      <= pend_end ? S_MARK : S_IDLE;
        end
        S_MARK: begin
          pad_active <= 1'b1;
          extra      <= (w >= AW'(WORDS - 2));
          fill_ptr   <= w + 1'b1;
          st         <= (w == AW'(WORDS - 1)) ? S_ADDR : S_FILL;
        end
        S_FILL: begin
          fill_ptr <= fill_ptr + 1'b1;
          if (fill_ptr == AW'(WORDS - 1)) begin
            st <= S_ADDR;
          end
        end
        S_ADDR: begin
          rnd <= '0;
          st  <= S_PRIME;
        end
        S_PRIME: begin
          st <= S_ROUND;
        end
        S_ROUND: begin
          rnd <= rnd + 1'b1;
          if (rnd == md5sh_pkg::RND_W'(63)) begin
            st <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (pad_active) begin
            if (extra) begin
              extra    <= 1'b0;
              fill_ptr <= '0;
              st       <= S_FILL;
            end else begin
              st <= S_EMIT;
            end
          end else if (pend_hi) begin
            st <= S_HI;
          end else if (pend_end) begin
            st <= S_MARK;
          end else begin
            st <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (!q_busy) begin
            len        <= '0;
            pad_active <= 1'b0;
            pend_end   <= 1'b0;
            st         <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  md5sh_block_ram #(
    .WORDS(WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wbe  (ram_wbe),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  md5sh_round_unit u_round (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .mword(ram_rdata),
    .chain(chain)
  );

  md5sh_out_queue u_out (
    .clk  (clk),
    .rst  (rst),
    .load (q_load),
    .words(chain),
    .busy (q_busy),
    .dig  (dig)
  );

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    q_load |-> !q_busy)
    else $error("digest handed over while output still busy");

  a_len_cleared: assert property (@(posedge clk) disable iff (rst)
    (st == S_EMIT) && !q_busy |=> len == '0)
    else $error("length not cleared after digest");

  a_full_rounds: assert property (@(posedge clk) disable iff (rst)
    (st == S_FINAL) |-> ($past(st) == S_ROUND) && ($past(rnd) == md5sh_pkg::RND_W'(63)))
    else $error("compression finished before round 63");

  a_pad_done: assert property (@(posedge clk) disable iff (rst)
    (st == S_EMIT) |-> pad_active && !extra)
    else $error("digest with padding incomplete");

endmodule
`default_nettype wire

/* tb/md5_digest_checker.sv */
// Digest checker for the MD5 stream hasher: predicts digest words from accepted items.
module md5_digest_checker (
  input  logic clk,
  input  logic rst,
  md5sh_in_if  msg,
  md5sh_out_if dig,
  output int   mismatches,
  output int   outstanding
);

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  index;
    logic        last;
  } digest_item_t;

  digest_item_t digest_q[$];

  logic [31:0] sine_k [64];
  logic [31:0] chain [4];
  logic [7:0]  block_bytes [64];
  logic [63:0] msg_len;

  initial begin : build_sine_table
    real r;
    for (int i = 0; i < 64; i++) begin
      r = $sin(i + 1);
      if (r < 0.0) r = -r;
      sine_k[i] = 32'(longint'($floor(r * 4294967296.0)));
    end
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic int shift_of(input int grp, input int k);
    int row [4];
    case (grp)
      0:       row = '{7, 12, 17, 22};
      1:       row = '{5, 9, 14, 20};
      2:       row = '{4, 11, 16, 23};
      default: row = '{6, 10, 15, 21};
    endcase
    return row[k];
  endfunction

  task automatic restore_chain();
    chain[0] = 32'h67452301;
    chain[1] = 32'hEFCDAB89;
    chain[2] = 32'h98BADCFE;
    chain[3] = 32'h10325476;
    msg_len  = '0;
  endtask

  task automatic md5_compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    for (int i = 0; i < 16; i++) begin
      m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = d ^ (b & (c ^ d));
          g = i;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotl32(a + f + sine_k[i] + m[g], shift_of(i / 16, i % 4));
      a = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endtask

  task automatic place_byte(input int pos_in, input logic [7:0] v, output int pos_out);
    block_bytes[pos_in % 64] = v;
    pos_out = (pos_in % 64) + 1;
    if (pos_out == 64) begin
      md5_compress();
      pos_out = 0;
    end
  endtask

  task automatic hash_item(input logic [31:0] w, input logic [2:0] code, input logic eom);
    int n, p;
    logic [63:0] bits;
    digest_item_t d;
    n = (code > 3'd4) ? 4 : int'(code);
    for (int i = 0; i < n; i++) begin
      place_byte(int'(msg_len[5:0]), w[8*i +: 8], p);
      msg_len = msg_len + 1;
    end
    if (eom) begin
      bits = msg_len << 3;
      place_byte(int'(msg_len[5:0]), 8'h80, p);
      while (p != 56) place_byte(p, 8'h00, p);
      for (int i = 0; i < 8; i++) place_byte(p, bits[8*i +: 8], p);
      for (int i = 0; i < 4; i++) begin
        d.word  = chain[i];
        d.index = 2'(i);
        d.last  = (i == 3);
        digest_q.push_back(d);
      end
      restore_chain();
    end
  endtask

  task automatic check_digest();
    digest_item_t got, want;
    got = '{word: dig.digest_word, index: dig.word_index, last: dig.last_word};
    if (digest_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected digest word %h index %0d last %0b", got.word, got.index, got.last);
    end else begin
      want = digest_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest mismatch: expected %h idx %0d last %0b, got %h idx %0d last %0b",
                   want.word, want.index, want.last, got.word, got.index, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restore_chain();
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
    end else begin
      if (dig.valid && dig.ready) check_digest();
      if (msg.valid && msg.ready) hash_item(msg.data_word, msg.byte_count, msg.end_of_message);
    end
    outstanding = digest_q.size();
  end

endmodule

/* tb/md5_stream_hasher_tb.sv */
// Testbench top for the MD5 stream hasher: clock, reset, message stimulus and verdict.
module md5_stream_hasher_tb;

  logic clk;
  logic rst;
  logic no_gaps;
  logic stall_hold;
  int   fail_count;
  int   pending;
  int   items_sent;

  md5sh_in_if  msg_if ();
  md5sh_out_if dig_if ();

  md5_stream_hasher DUT (
    .clk (clk),
    .rst (rst),
    .msg (msg_if),
    .dig (dig_if)
  );

  md5_digest_checker chk (
    .clk         (clk),
    .rst         (rst),
    .msg         (msg_if),
    .dig         (dig_if),
    .mismatches  (fail_count),
    .outstanding (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[md5_stream_hasher] ERROR");
    $finish;
  end

  // long receiver stall so the next message backs up into the input
  initial begin
    stall_hold = 1'b0;
    wait (!rst);
    repeat (400) @(posedge clk);
    stall_hold <= 1'b1;
    repeat (1500) @(posedge clk);
    stall_hold <= 1'b0;
  end

  initial begin : digest_sink
    int hold_left;
    dig_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        dig_if.ready <= 1'b0;
      end else begin
        if (dig_if.valid && dig_if.ready) hold_left = no_gaps ? 0 : $urandom_range(0, 5);
        else if (hold_left > 0) hold_left--;
        dig_if.ready <= (hold_left == 0) && !stall_hold;
      end
    end
  end

  task automatic offer(input logic [31:0] w, input logic [2:0] code, input logic eom);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_if.valid          <= 1'b1;
    msg_if.data_word      <= w;
    msg_if.byte_count     <= code;
    msg_if.end_of_message <= eom;
    do @(posedge clk); while (!msg_if.ready);
    items_sent++;
  endtask

  task automatic send_message(input int len);
    int left, take;
    logic [2:0] code;
    logic done;
    left = len;
    done = 1'b0;
    while (!done) begin
      code = 3'($urandom_range(0, 7));
      take = (code > 3'd4) ? 4 : int'(code);
      if (take > left) begin
        take = left;
        code = 3'(left);
      end
      left -= take;
      if (left == 0 && $urandom_range(0, 3) != 0) begin
        offer($urandom, code, 1'b1);
        done = 1'b1;
      end else begin
        offer($urandom, code, 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    int len;
    rst                   = 1'b1;
    no_gaps               = 1'b0;
    items_sent            = 0;
    msg_if.valid          = 1'b0;
    msg_if.data_word      = '0;
    msg_if.byte_count     = '0;
    msg_if.end_of_message = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty message, then "abc"
    offer(32'h0000_0000, 3'd0, 1'b1);
    offer(32'h0063_6261, 3'd3, 1'b1);
    // saturating counts, extreme data, zero-byte filler, short end item
    offer(32'hFFFF_FFFF, 3'd7, 1'b0);
    offer(32'h0000_0000, 3'd4, 1'b0);
    offer(32'hA5A5_A5A5, 3'd5, 1'b0);
    offer(32'hDEAD_BEEF, 3'd0, 1'b0);
    offer(32'h5A5A_5A5A, 3'd6, 1'b0);
    offer(32'hFFFF_FFFF, 3'd1, 1'b0);
    offer(32'h1234_5678, 3'd2, 1'b1);
    // full end item, then a full item and an end mark with no bytes
    offer(32'hFFFF_FFFF, 3'd4, 1'b1);
    offer(32'h8000_0001, 3'd4, 1'b0);
    offer(32'hFFFF_FFFF, 3'd0, 1'b1);

    while (items_sent < 262) begin
      no_gaps <= ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: len = $urandom_range(0, 64);
        5, 6: begin
          case ($urandom_range(0, 7))
            0:       len = 55;
            1:       len = 56;
            2:       len = 57;
            3:       len = 63;
            4:       len = 64;
            5:       len = 65;
            6:       len = 119;
            default: len = 120;
          endcase
        end
        7, 8:    len = $urandom_range(0, 12);
        default: len = $urandom_range(100, 200);
      endcase
      send_message(len);
    end
    msg_if.valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("[md5_stream_hasher] OK");
    end else begin
      $display("[md5_stream_hasher] ERROR");
    end
    $finish;
  end

endmodule
